@@ src/bmh_pkg.sv @@
package bmh_pkg;

  localparam int HEAP_DEPTH_DEF = 1024;
  localparam int IDX_W = 11;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_BUILD  = 3'd1,
    OP_INSERT = 3'd2,
    OP_INCR   = 3'd3,
    OP_SET    = 3'd4,
    OP_SORT   = 3'd5,
    OP_READ   = 3'd6,
    OP_CLEAR  = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SMALLER = 2'd1,
    ST_FULL    = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]        opcode;
    logic signed [31:0] key_value;
    logic [IDX_W-1:0]  entry_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [IDX_W-1:0]   entry_count;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_IDX,    // wait read of entry at index
    S_CHK_IDX,   // data of entry at index available
    S_UP_RD,     // read parent
    S_UP_CHK,    // parent data available
    S_UP_WR,     // write moving key at parent position
    S_BLD_NEXT,  // pick next sift-down root for build
    S_DN_RD,     // read current entry
    S_DN_RDL,    // current data, read left
    S_DN_RDR,    // left data, read right
    S_DN_CHK,    // right data, decide
    S_DN_SW,     // write second half of swap
    S_SRT_NEXT,  // heapsort extraction step
    S_SRT_RD1,
    S_SRT_RDN,
    S_SRT_SW,
    S_TOP_RD,    // read position one for result
    S_TOP_WT,
    S_OUT
  } state_t;

endpackage

@@ src/binary_max_heap_engine_unit.sv @@
// binary max heap engine: one item in flight, one result per item
// result path: clear goes straight to the result, read and append follow one memory read,
// insert and increase sift up (log2 of the depth levels at most), build/set/sort sift down
// throughput: one item at a time, next one taken the cycle after the result leaves
// reset: count cleared, memory contents undefined until written, no clearing pass
module binary_max_heap_engine_unit #(
  parameter int HEAP_DEPTH = bmh_pkg::HEAP_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  bmh_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bmh_pkg::out_item_t out_data
);
  import bmh_pkg::*;

  localparam int AW = $clog2(HEAP_DEPTH + 1);
  localparam int PW = AW + 1;

  // heap memory, positions 1..HEAP_DEPTH
  logic signed [31:0] mem [0:HEAP_DEPTH];
  logic [AW-1:0]      raddr, waddr;
  logic               we;
  logic signed [31:0] wdata, rdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  state_t state, state_next;
  logic [PW-1:0] count, count_next;
  logic [PW-1:0] pos, pos_next;      // current position
  logic [PW-1:0] root, root_next;    // build root counter
  logic [PW-1:0] size, size_next;    // sift-down limit
  logic [PW-1:0] top, top_next;
  logic signed [31:0] cur, cur_next, lv, lv_next, tv, tv_next;
  opcode_t op, op_next;
  logic signed [31:0] key, key_next;
  logic [PW-1:0] idx, idx_next;
  logic [1:0] st, st_next;
  logic signed [31:0] rv, rv_next;
  logic sorting, sorting_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = '{status: st, read_value: rv, entry_count: count[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    pos <= pos_next; root <= root_next; size <= size_next; top <= top_next;
    cur <= cur_next; lv <= lv_next; tv <= tv_next; op <= op_next;
    key <= key_next; idx <= idx_next; st <= st_next; rv <= rv_next;
    sorting <= sorting_next;
  end

  logic idx_ok;
  assign idx_ok = (idx != '0) && (idx <= count);

  // sequencer
  always_comb begin
    state_next = state; count_next = count; pos_next = pos; root_next = root;
    size_next = size; top_next = top; cur_next = cur; lv_next = lv; tv_next = tv;
    op_next = op; key_next = key; idx_next = idx; st_next = st; rv_next = rv;
    sorting_next = sorting;
    raddr = pos[AW-1:0]; waddr = pos[AW-1:0]; we = 1'b0; wdata = key;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next  = opcode_t'(in_data.opcode);
          key_next = in_data.key_value;
          idx_next = PW'(in_data.entry_index);
          st_next  = ST_OK;
          rv_next  = '0;
          sorting_next = 1'b0;
          state_next = S_RD_IDX;
          raddr = AW'(in_data.entry_index);
          case (opcode_t'(in_data.opcode))
            OP_APPEND, OP_INSERT: begin
              if (count >= PW'(HEAP_DEPTH)) begin
                st_next = ST_FULL; state_next = S_TOP_RD;
              end else begin
                we = 1'b1; waddr = AW'(count + 1'b1); wdata = in_data.key_value;
                count_next = count + 1'b1;
                pos_next = count + 1'b1;
                state_next = (opcode_t'(in_data.opcode) == OP_INSERT) ? S_UP_RD : S_TOP_RD;
              end
            end
            OP_BUILD: begin root_next = count >> 1; size_next = count; state_next = S_BLD_NEXT; end
            OP_SORT: begin
              root_next = count >> 1; size_next = count; sorting_next = 1'b1;
              state_next = S_BLD_NEXT;
            end
            OP_CLEAR: begin count_next = '0; state_next = S_OUT; end
            default: state_next = S_RD_IDX;
          endcase
        end
      end
      S_RD_IDX: begin raddr = idx[AW-1:0]; state_next = S_CHK_IDX; end
      S_CHK_IDX: begin
        if (!idx_ok) begin
          st_next = ST_RANGE;
          state_next = (op == OP_READ) ? S_OUT : S_TOP_RD;
        end else if (op == OP_READ) begin
          rv_next = rdata; state_next = S_OUT;
        end else if (op == OP_INCR && key < rdata) begin
          st_next = ST_SMALLER; state_next = S_TOP_RD;
        end else begin
          we = 1'b1; waddr = idx[AW-1:0]; wdata = key; pos_next = idx;
          if (op == OP_INCR) state_next = S_UP_RD;
          else begin root_next = count >> 1; size_next = count; state_next = S_BLD_NEXT; end
        end
      end
      // sift up: key is the moving value at pos
      S_UP_RD: begin
        if (pos <= 1) state_next = S_TOP_RD;
        else begin raddr = AW'(pos >> 1); state_next = S_UP_CHK; end
      end
      S_UP_CHK: begin
        if (rdata < key) begin
          we = 1'b1; waddr = pos[AW-1:0]; wdata = rdata;
          pos_next = pos >> 1; state_next = S_UP_WR;
        end else state_next = S_TOP_RD;
      end
      S_UP_WR: begin
        we = 1'b1; waddr = pos[AW-1:0]; wdata = key; state_next = S_UP_RD;
      end
      // build: roots from count/2 down to 1
      S_BLD_NEXT: begin
        if (root == '0) begin
          if (sorting) begin size_next = count; state_next = S_SRT_NEXT; end
          else state_next = S_TOP_RD;
        end else begin
          pos_next = root; root_next = root - 1'b1; state_next = S_DN_RD;
        end
      end
      S_DN_RD: begin raddr = pos[AW-1:0]; state_next = S_DN_RDL; end
      S_DN_RDL: begin
        cur_next = rdata; raddr = AW'(pos << 1); state_next = S_DN_RDR;
      end
      S_DN_RDR: begin
        lv_next = rdata; raddr = AW'((pos << 1) + 1'b1); state_next = S_DN_CHK;
      end
      S_DN_CHK: begin
        top_next = pos; tv_next = cur;
        if ((pos << 1) <= size && lv > cur) begin top_next = pos << 1; tv_next = lv; end
        if ((pos << 1) + 1'b1 <= size &&
            rdata > (((pos << 1) <= size && lv > cur) ? lv : cur)) begin
          top_next = (pos << 1) + 1'b1; tv_next = rdata;
        end
        if (top_next == pos) state_next = sorting && root == '0 ? S_SRT_NEXT : S_BLD_NEXT;
        else begin
          we = 1'b1; waddr = pos[AW-1:0]; wdata = tv_next; state_next = S_DN_SW;
        end
      end
      S_DN_SW: begin
        we = 1'b1; waddr = top[AW-1:0]; wdata = cur; pos_next = top; state_next = S_DN_RD;
      end
      // sort: swap 1 with size then sift down over size-1
      S_SRT_NEXT: begin
        if (size < 2) state_next = S_TOP_RD;
        else begin raddr = '0 + AW'(1); state_next = S_SRT_RD1; end
      end
      S_SRT_RD1: begin cur_next = rdata; raddr = size[AW-1:0]; state_next = S_SRT_RDN; end
      S_SRT_RDN: begin
        we = 1'b1; waddr = AW'(1); wdata = rdata; state_next = S_SRT_SW;
      end
      S_SRT_SW: begin
        we = 1'b1; waddr = size[AW-1:0]; wdata = cur;
        size_next = size - 1'b1; pos_next = PW'(1); state_next = S_DN_RD;
      end
      S_TOP_RD: begin raddr = AW'(1); state_next = S_TOP_WT; end
      S_TOP_WT: begin
        rv_next = (count != '0) ? rdata : '0; state_next = S_OUT;
      end
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= PW'(HEAP_DEPTH))
    else $error("count above depth");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken with result pending");
`endif
endmodule

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bmh_pkg::*;

  localparam int DEPTH = HEAP_DEPTH_DEF;
  localparam int IDLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  binary_max_heap_engine_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the heap
  logic signed [31:0] shadow_heap [1:DEPTH];
  int unsigned shadow_count;
  out_item_t pending_results[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit hold_receiver = 1'b0;
  bit hold_start = 1'b0;

  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic signed [31:0] t;
    t = shadow_heap[a];
    shadow_heap[a] = shadow_heap[b];
    shadow_heap[b] = t;
  endfunction

  function automatic void sink_entry(int unsigned pos, int unsigned size);
    int unsigned top;
    forever begin
      top = pos;
      if (2*pos <= size && shadow_heap[2*pos] > shadow_heap[top]) top = 2*pos;
      if (2*pos+1 <= size && shadow_heap[2*pos+1] > shadow_heap[top]) top = 2*pos+1;
      if (top == pos) return;
      swap_entries(pos, top);
      pos = top;
    end
  endfunction

  function automatic void raise_entry(int unsigned pos);
    while (pos > 1 && shadow_heap[pos/2] < shadow_heap[pos]) begin
      swap_entries(pos, pos/2);
      pos = pos / 2;
    end
  endfunction

  function automatic void heapify_all();
    for (int unsigned p = shadow_count / 2; p >= 1; p--) sink_entry(p, shadow_count);
  endfunction

  // apply one transaction to the shadow heap and return its expected result
  function automatic out_item_t apply_heap_op(in_item_t it);
    out_item_t r;
    bit idx_ok;
    bit is_read;
    idx_ok = it.entry_index >= 1 && it.entry_index <= shadow_count;
    is_read = 1'b0;
    r.status = ST_OK;
    r.read_value = '0;
    case (opcode_t'(it.opcode))
      OP_APPEND, OP_INSERT: begin
        if (shadow_count >= DEPTH) r.status = ST_FULL;
        else begin
          shadow_count++;
          shadow_heap[shadow_count] = it.key_value;
          if (it.opcode == OP_INSERT) raise_entry(shadow_count);
        end
      end
      OP_BUILD: heapify_all();
      OP_INCR: begin
        if (!idx_ok) r.status = ST_RANGE;
        else if (it.key_value < shadow_heap[it.entry_index]) r.status = ST_SMALLER;
        else begin
          shadow_heap[it.entry_index] = it.key_value;
          raise_entry(it.entry_index);
        end
      end
      OP_SET: begin
        if (!idx_ok) r.status = ST_RANGE;
        else begin
          shadow_heap[it.entry_index] = it.key_value;
          heapify_all();
        end
      end
      OP_SORT: begin
        heapify_all();
        for (int unsigned s = shadow_count; s >= 2; s--) begin
          swap_entries(1, s);
          sink_entry(1, s - 1);
        end
      end
      OP_READ: begin
        is_read = 1'b1;
        if (!idx_ok) r.status = ST_RANGE;
        else r.read_value = shadow_heap[it.entry_index];
      end
      default: shadow_count = 0;
    endcase
    if (!is_read && shadow_count >= 1) r.read_value = shadow_heap[1];
    r.entry_count = shadow_count[IDX_W-1:0];
    return r;
  endfunction

  // send one transaction and wait until it is taken; expected result typed in or predicted
  task automatic send_item(in_item_t it, bit has_typed, out_item_t typed);
    out_item_t predicted;
    in_valid <= 1'b1;
    in_data <= it;
    predicted = apply_heap_op(it);
    if (has_typed) pending_results.push_back(typed);
    else pending_results.push_back(predicted);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic maybe_gap();
    int gap;
    if ($urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic in_item_t make_item(opcode_t op, logic signed [31:0] k, int idx);
    in_item_t it;
    it.opcode = op;
    it.key_value = k;
    it.entry_index = idx[IDX_W-1:0];
    return it;
  endfunction

  function automatic out_item_t make_result(status_t st, logic signed [31:0] v, int cnt);
    out_item_t r;
    r.status = st;
    r.read_value = v;
    r.entry_count = cnt[IDX_W-1:0];
    return r;
  endfunction

  function automatic logic signed [31:0] rand_key();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed($urandom_range(0, 40)) - 20;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic int rand_index();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return shadow_count + 1;
      2: return $urandom_range(0, 2047);
      default: return shadow_count == 0 ? 0 : $urandom_range(1, shadow_count);
    endcase
  endfunction

  typedef struct {
    in_item_t stim;
    bit has_typed;
    out_item_t typed;
  } directed_row_t;

  directed_row_t directed_rows[$];

  task automatic add_row(opcode_t op, logic signed [31:0] k, int idx, bit ht = 0,
                         status_t st = ST_OK, logic signed [31:0] v = 0, int cnt = 0);
    directed_row_t row;
    row.stim = make_item(op, k, idx);
    row.has_typed = ht;
    row.typed = make_result(st, v, cnt);
    directed_rows.push_back(row);
  endtask

  // output check and receiver stall pattern
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result %p", out_data);
        end else begin
          exp_r = pending_results.pop_front();
          if (out_data.status !== exp_r.status || out_data.read_value !== exp_r.read_value
              || out_data.entry_count !== exp_r.entry_count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected %p got %p", exp_r, out_data);
          end
        end
      end
      if (hold_receiver) out_stall <= 1'b1;
      else if (($urandom_range(0, 63) < 40) && $urandom_range(0, 3) == 0)
        out_stall <= 1'b1;
      else out_stall <= 1'b0;
    end
  end

  // long receiver hold, counted in cycles
  initial begin
    wait (hold_start);
    @(posedge clk);
    hold_receiver <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_receiver <= 1'b0;
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL binary_max_heap_engine_unit");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    int n_sent;
    int drain_wait;
    shadow_count = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part: empty store, extremes, errors, every opcode
    add_row(OP_READ, 0, 1, 1, ST_RANGE, 0, 0);
    add_row(OP_BUILD, 0, 0, 1, ST_OK, 0, 0);
    add_row(OP_SORT, 0, 0, 1, ST_OK, 0, 0);
    add_row(OP_INCR, 5, 1, 1, ST_RANGE, 0, 0);
    add_row(OP_SET, 5, 0, 1, ST_RANGE, 0, 0);
    add_row(OP_APPEND, 32'sh8000_0000, 0, 1, ST_OK, 32'sh8000_0000, 1);
    add_row(OP_APPEND, 32'sh7fff_ffff, 2047, 1, ST_OK, 32'sh8000_0000, 2);
    add_row(OP_APPEND, -1, 0);
    add_row(OP_READ, 0, 0, 1, ST_RANGE, 0, 3);
    add_row(OP_READ, 0, 4, 1, ST_RANGE, 0, 3);
    add_row(OP_READ, 0, 2, 1, ST_OK, 32'sh7fff_ffff, 3);
    add_row(OP_BUILD, 0, 0, 1, ST_OK, 32'sh7fff_ffff, 3);
    add_row(OP_INCR, 32'sh8000_0000, 3, 1, ST_SMALLER, 32'sh7fff_ffff, 3);
    add_row(OP_INCR, 100, 3);
    add_row(OP_INSERT, 42, 0);
    add_row(OP_INSERT, 32'sh8000_0000, 0);
    add_row(OP_SET, -7, 1);
    add_row(OP_SORT, 0, 0);
    add_row(OP_INSERT, 1000, 0);
    add_row(OP_READ, 0, 6);
    add_row(OP_CLEAR, 0, 0, 1, ST_OK, 0, 0);
    add_row(OP_INSERT, 9, 0, 1, ST_OK, 9, 1);
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].stim, directed_rows[i].has_typed, directed_rows[i].typed);
      maybe_gap();
    end

    // sender pause until everything has drained
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    // random part: mostly inserts and queries on a small heap
    n_sent = 0;
    while (n_sent < 928) begin
      if (n_sent == 300) hold_start = 1'b1;
      case ($urandom_range(0, 19))
        0, 1, 2: it = make_item(OP_APPEND, rand_key(), rand_index());
        3: it = make_item(OP_BUILD, rand_key(), rand_index());
        4, 5, 6, 7: it = make_item(OP_INSERT, rand_key(), rand_index());
        8, 9, 10: it = make_item(OP_INCR, rand_key(), rand_index());
        11: it = make_item(OP_SET, rand_key(), rand_index());
        12: it = make_item(OP_SORT, rand_key(), rand_index());
        13: it = make_item(shadow_count > 40 ? OP_CLEAR : OP_READ, rand_key(), rand_index());
        default: it = make_item(OP_READ, rand_key(), rand_index());
      endcase
      send_item(it, 0, '0);
      n_sent++;
      if (!hold_receiver) maybe_gap();
    end
    in_valid <= 1'b0;

    drain_wait = 0;
    while (pending_results.size() != 0 && drain_wait < IDLE_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("PASS binary_max_heap_engine_unit");
    else
      $display("FAIL binary_max_heap_engine_unit");
    $finish;
  end

endmodule

@@ binary_max_heap_engine_unit.f @@
src/bmh_pkg.sv
src/binary_max_heap_engine_unit.sv
tb/tb.sv
